>>> sv/slt_pkg.sv
// ============================================================================
// slt_pkg
// Shared types, character codes, token kinds and the keyword matcher of the
// script lexer tokenizer.
// ============================================================================
package slt_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int TOKEN_POS_BITS        = 16;
    localparam int QUEUE_DEPTH           = 4;
    localparam int QUEUE_PTR_BITS        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS        = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DIG_0  = 8'h30;
    localparam logic [7:0] CH_DIG_9  = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_I   = 8'h69;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_EQ      = 3'd1,
        MODE_BANG    = 3'd2,
        MODE_MINUS   = 3'd3,
        MODE_STRING  = 3'd4,
        MODE_WORD    = 3'd5,
        MODE_NUMBER  = 3'd6,
        MODE_INVALID = 3'd7
    } scan_mode_e;

    typedef enum logic [4:0] {
        TK_EOF     = 5'd0,
        TK_EOL     = 5'd1,
        TK_EQEQ    = 5'd2,
        TK_EQ      = 5'd3,
        TK_BANGEQ  = 5'd4,
        TK_BANG    = 5'd5,
        TK_LPAREN  = 5'd6,
        TK_RPAREN  = 5'd7,
        TK_COLON   = 5'd8,
        TK_COMMA   = 5'd9,
        TK_ARROW   = 5'd10,
        TK_MINUS   = 5'd11,
        TK_PLUS    = 5'd12,
        TK_STAR    = 5'd13,
        TK_SLASH   = 5'd14,
        TK_STRING  = 5'd15,
        TK_FN      = 5'd16,
        TK_FALSE   = 5'd17,
        TK_NIL     = 5'd18,
        TK_TRUE    = 5'd19,
        TK_VAR     = 5'd20,
        TK_IDENT   = 5'd21,
        TK_NUMBER  = 5'd22,
        TK_INVALID = 5'd23
    } tok_kind_e;

    // Keyword candidate: which prefix of which keyword has matched so far.
    typedef enum logic [3:0] {
        KW_NONE = 4'd0,
        KW_F    = 4'd1,
        KW_FA   = 4'd2,
        KW_FAL  = 4'd3,
        KW_FALS = 4'd4,
        KW_N    = 4'd5,
        KW_NI   = 4'd6,
        KW_T    = 4'd7,
        KW_TR   = 4'd8,
        KW_TRU  = 4'd9,
        KW_V    = 4'd10,
        KW_VA   = 4'd11
    } kw_prog_e;

    typedef struct packed {
        logic      done;
        tok_kind_e kind;
        kw_prog_e  prog;
    } kw_res_t;

    typedef struct packed {
        logic [TOKEN_POS_BITS-1:0] past;
        logic [TOKEN_POS_BITS-1:0] first;
        tok_kind_e                 kind;
    } tok_t;

    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } step_res_t;

    typedef struct packed {
        tok_t tok;
        logic last;
    } q_item_t;

    function automatic kw_res_t kw_step(kw_prog_e p, logic [7:0] b);
        kw_res_t r;
        r.done = 1'b0;
        r.kind = TK_EOF;
        r.prog = KW_NONE;
        case (p)
            KW_F: begin
                if (b == CH_LO_N) begin
                    r.done = 1'b1;
                    r.kind = TK_FN;
                end else if (b == CH_LO_A) begin
                    r.prog = KW_FA;
                end
            end
            KW_FA:   if (b == CH_LO_L) r.prog = KW_FAL;
            KW_FAL:  if (b == CH_LO_S) r.prog = KW_FALS;
            KW_FALS: begin
                if (b == CH_LO_E) begin
                    r.done = 1'b1;
                    r.kind = TK_FALSE;
                end
            end
            KW_N:    if (b == CH_LO_I) r.prog = KW_NI;
            KW_NI: begin
                if (b == CH_LO_L) begin
                    r.done = 1'b1;
                    r.kind = TK_NIL;
                end
            end
            KW_T:    if (b == CH_LO_R) r.prog = KW_TR;
            KW_TR:   if (b == CH_LO_U) r.prog = KW_TRU;
            KW_TRU: begin
                if (b == CH_LO_E) begin
                    r.done = 1'b1;
                    r.kind = TK_TRUE;
                end
            end
            KW_V:    if (b == CH_LO_A) r.prog = KW_VA;
            KW_VA: begin
                if (b == CH_LO_R) begin
                    r.done = 1'b1;
                    r.kind = TK_VAR;
                end
            end
            default: r.prog = KW_NONE;
        endcase
        return r;
    endfunction

endpackage

>>> sv/slt_step.sv
// ============================================================================
// slt_step
// Next-state and token logic for one source byte: closes the pending token
// and, where the byte starts anew, decodes the byte's own token.
// ============================================================================
module slt_step
    import slt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic [7:0]               text_byte,
    input  scan_mode_e               mode,
    input  kw_prog_e                 kw_prog,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [POSITION_BITS-1:0] pend_start,
    output scan_mode_e               mode_next,
    output kw_prog_e                 kw_prog_next,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic [POSITION_BITS-1:0] pend_start_next,
    output step_res_t                res
);

    logic [POSITION_BITS-1:0] pos_past;
    logic [TOKEN_POS_BITS-1:0] pos16;
    logic [TOKEN_POS_BITS-1:0] past16;
    logic [TOKEN_POS_BITS-1:0] start16;
    logic [POSITION_BITS+TOKEN_POS_BITS-1:0] pos_ext;
    logic [POSITION_BITS+TOKEN_POS_BITS-1:0] past_ext;
    logic [POSITION_BITS+TOKEN_POS_BITS-1:0] start_ext;

    logic is_zero, is_space, is_delim, is_digit, is_letter, is_term;
    logic restart, eof;
    kw_res_t kw;

    scan_mode_e start_mode;
    kw_prog_e   start_kw;
    logic       start_emit;
    tok_kind_e  start_kind;

    logic       tok_a_valid;
    tok_t       tok_a;
    tok_t       tok_b;

    // Position saturates at its all-ones value.
    assign pos_past = (pos == '1) ? pos : pos + POSITION_BITS'(1);

    assign pos_ext   = {{TOKEN_POS_BITS{1'b0}}, pos};
    assign past_ext  = {{TOKEN_POS_BITS{1'b0}}, pos_past};
    assign start_ext = {{TOKEN_POS_BITS{1'b0}}, pend_start};
    assign pos16     = pos_ext[TOKEN_POS_BITS-1:0];
    assign past16    = past_ext[TOKEN_POS_BITS-1:0];
    assign start16   = start_ext[TOKEN_POS_BITS-1:0];

    assign is_zero     = (text_byte == CH_NUL);
    assign is_space    = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                         (text_byte == CH_NL);
    assign is_delim    = (text_byte == CH_LPAREN) || (text_byte == CH_RPAREN) ||
                         (text_byte == CH_COLON)  || (text_byte == CH_COMMA)  ||
                         (text_byte == CH_STAR)   || (text_byte == CH_PLUS)   ||
                         (text_byte == CH_SLASH)  || (text_byte == CH_MINUS);
    assign is_digit    = (text_byte >= CH_DIG_0) && (text_byte <= CH_DIG_9);
    assign is_letter   = ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z)) ||
                         ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z));
    assign is_term     = is_space || is_zero || is_delim;

    assign kw = kw_step(kw_prog, text_byte);

    // The byte is handled as the start of new input when nothing is pending
    // or when it closes the pending token without being part of it.
    always_comb begin
        case (mode)
            MODE_IDLE:    restart = 1'b1;
            MODE_EQ:      restart = (text_byte != CH_EQ);
            MODE_BANG:    restart = (text_byte != CH_EQ);
            MODE_MINUS:   restart = (text_byte != CH_GT);
            MODE_STRING:  restart = is_zero;
            MODE_WORD:    restart = is_term;
            MODE_NUMBER:  restart = is_term;
            MODE_INVALID: restart = is_space || is_zero;
            default:      restart = 1'b1;
        endcase
    end

    assign eof = restart && is_zero;

    // Decode of a byte that starts a token.
    always_comb begin
        start_mode = MODE_IDLE;
        start_kw   = KW_NONE;
        start_emit = 1'b1;
        start_kind = TK_EOF;
        case (text_byte)
            CH_SPACE, CH_TAB: start_emit = 1'b0;
            CH_NUL:    start_kind = TK_EOF;
            CH_NL:     start_kind = TK_EOL;
            CH_LPAREN: start_kind = TK_LPAREN;
            CH_RPAREN: start_kind = TK_RPAREN;
            CH_COLON:  start_kind = TK_COLON;
            CH_COMMA:  start_kind = TK_COMMA;
            CH_PLUS:   start_kind = TK_PLUS;
            CH_STAR:   start_kind = TK_STAR;
            CH_SLASH:  start_kind = TK_SLASH;
            CH_EQ: begin
                start_emit = 1'b0;
                start_mode = MODE_EQ;
            end
            CH_BANG: begin
                start_emit = 1'b0;
                start_mode = MODE_BANG;
            end
            CH_MINUS: begin
                start_emit = 1'b0;
                start_mode = MODE_MINUS;
            end
            CH_QUOTE: begin
                start_emit = 1'b0;
                start_mode = MODE_STRING;
            end
            default: begin
                start_emit = 1'b0;
                if (is_letter) begin
                    start_mode = MODE_WORD;
                    case (text_byte)
                        CH_LO_F: start_kw = KW_F;
                        CH_LO_N: start_kw = KW_N;
                        CH_LO_T: start_kw = KW_T;
                        CH_LO_V: start_kw = KW_V;
                        default: start_kw = KW_NONE;
                    endcase
                end else if (is_digit) begin
                    start_mode = MODE_NUMBER;
                end else begin
                    start_mode = MODE_INVALID;
                end
            end
        endcase
    end

    // Next state.
    always_comb begin
        mode_next       = mode;
        kw_prog_next    = kw_prog;
        pend_start_next = pend_start;
        pos_next        = pos_past;
        if (eof) begin
            mode_next       = MODE_IDLE;
            kw_prog_next    = KW_NONE;
            pend_start_next = '0;
            pos_next        = '0;
        end else if (restart) begin
            mode_next       = start_mode;
            kw_prog_next    = start_kw;
            pend_start_next = pos;
        end else begin
            case (mode)
                MODE_EQ, MODE_BANG, MODE_MINUS, MODE_STRING: begin
                    // Only a byte that completes the token gets here, apart
                    // from the body of a string.
                    if (mode != MODE_STRING || text_byte == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_WORD: begin
                    if (kw_prog != KW_NONE) begin
                        if (kw.done) begin
                            mode_next    = MODE_IDLE;
                            kw_prog_next = KW_NONE;
                        end else begin
                            kw_prog_next = kw.prog;
                        end
                    end
                end
                MODE_NUMBER: begin
                    if (!is_digit) begin
                        mode_next = MODE_INVALID;
                    end
                end
                default: mode_next = mode;
            endcase
        end
    end

    // Tokens: the closed pending token first, then the byte's own token.
    always_comb begin
        tok_a_valid = 1'b0;
        tok_a.kind  = TK_EOF;
        tok_a.first = start16;
        tok_a.past  = pos16;
        case (mode)
            MODE_EQ: begin
                tok_a_valid = 1'b1;
                tok_a.kind  = restart ? TK_EQ : TK_EQEQ;
                tok_a.past  = restart ? pos16 : past16;
            end
            MODE_BANG: begin
                tok_a_valid = 1'b1;
                tok_a.kind  = restart ? TK_BANG : TK_BANGEQ;
                tok_a.past  = restart ? pos16 : past16;
            end
            MODE_MINUS: begin
                tok_a_valid = 1'b1;
                tok_a.kind  = restart ? TK_MINUS : TK_ARROW;
                tok_a.past  = restart ? pos16 : past16;
            end
            MODE_STRING: begin
                tok_a_valid = is_zero || (text_byte == CH_QUOTE);
                tok_a.kind  = TK_STRING;
                tok_a.past  = is_zero ? pos16 : past16;
            end
            MODE_WORD: begin
                tok_a_valid = is_term || ((kw_prog != KW_NONE) && kw.done);
                tok_a.kind  = is_term ? TK_IDENT : kw.kind;
                tok_a.past  = is_term ? pos16 : past16;
            end
            MODE_NUMBER: begin
                tok_a_valid = is_term;
                tok_a.kind  = TK_NUMBER;
            end
            MODE_INVALID: begin
                tok_a_valid = is_space || is_zero;
                tok_a.kind  = TK_INVALID;
            end
            default: tok_a_valid = 1'b0;
        endcase

        tok_b.kind  = start_kind;
        tok_b.first = pos16;
        tok_b.past  = past16;

        res.tok1 = tok_b;
        if (tok_a_valid) begin
            res.tok0  = tok_a;
            res.count = (restart && start_emit) ? 2'd2 : 2'd1;
        end else begin
            res.tok0  = tok_b;
            res.count = (restart && start_emit) ? 2'd1 : 2'd0;
        end
    end

endmodule

>>> sv/slt_queue.sv
// ============================================================================
// slt_queue
// Small result queue: takes up to two tokens per cycle, hands out one, and
// keeps room for a full byte's worth of tokens before taking the next byte.
// ============================================================================
module slt_queue
    import slt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push0,
    input  logic    push1,
    input  q_item_t item0,
    input  q_item_t item1,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output q_item_t out_item,
    output logic [QUEUE_CNT_BITS-1:0] fill
);

    q_item_t                   slots [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                      pop;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = slots[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
    assign fill      = cnt_reg;

    assign wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push0) + QUEUE_PTR_BITS'(push1);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
    assign cnt_next    = cnt_reg + QUEUE_CNT_BITS'(push0) + QUEUE_CNT_BITS'(push1)
                         - QUEUE_CNT_BITS'(pop);

    always_ff @(posedge aclk) begin
        if (push0) begin
            slots[wr_ptr_reg] <= item0;
        end
        if (push1) begin
            slots[wr_ptr_reg + QUEUE_PTR_BITS'(1)] <= item1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> sv/script_lexer_tokenizer_unit.sv
// ============================================================================
// script_lexer_tokenizer_unit
// Streaming lexer: one source byte per item in, tokens out as they complete.
// ============================================================================
// A token enters the result queue registers with the byte that completes it.
// Throughput: one byte per cycle; a byte may yield up to two tokens, and the
// four-entry result queue takes a byte only while it has room for two.
// Reset: synchronous, active low; clears scan state, position and the queue.
module script_lexer_tokenizer_unit
    import slt_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [4:0] token_kind, [20:5] token_first,
                                   // [36:21] token_past_end, [39:37] zero
    output logic        m_tlast    // run_last
);

    scan_mode_e               mode_reg, mode_next;
    kw_prog_e                 kw_reg, kw_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    step_res_t                res;
    logic                     s_accept;
    q_item_t                  item0, item1, out_item;
    logic [QUEUE_CNT_BITS-1:0] q_fill;

    assign s_accept = s_tvalid && s_tready;

    slt_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .text_byte       (s_tdata),
        .mode            (mode_reg),
        .kw_prog         (kw_reg),
        .pos             (pos_reg),
        .pend_start      (start_reg),
        .mode_next       (mode_next),
        .kw_prog_next    (kw_next),
        .pos_next        (pos_next),
        .pend_start_next (start_next),
        .res             (res)
    );

    assign item0.tok  = res.tok0;
    assign item0.last = (res.count == 2'd1);
    assign item1.tok  = res.tok1;
    assign item1.last = 1'b1;

    slt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (s_accept && (res.count != 2'd0)),
        .push1     (s_accept && (res.count == 2'd2)),
        .item0     (item0),
        .item1     (item1),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .fill      (q_fill)
    );

    assign m_tdata = {3'b000, out_item.tok.past, out_item.tok.first, out_item.tok.kind};
    assign m_tlast = out_item.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            kw_reg    <= KW_NONE;
            pos_reg   <= '0;
            start_reg <= '0;
        end else if (s_accept) begin
            mode_reg  <= mode_next;
            kw_reg    <= kw_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
        end
    end

    // The queue never holds more entries than it has.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_fill <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A zero byte always ends the buffer, so positions restart.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tdata == CH_NUL) |=> (pos_reg == '0) && (mode_reg == MODE_IDLE))
        else $error("position not restarted after end of buffer");

    // Any other byte advances the position by one until it saturates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_tdata != CH_NUL) && (pos_reg != '1)
        |=> pos_reg == $past(pos_reg) + POSITION_BITS'(1))
        else $error("position did not advance");

    // A keyword candidate only exists inside a word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg != MODE_WORD) |-> (kw_reg == KW_NONE))
        else $error("keyword candidate outside a word");

endmodule
